>>> hw/rtl/bmhq_pkg.sv
// Package for the max-heap priority queue: sizes, command and status codes,
// and the control struct that the top level hands to every cell.
// Depends on nothing.
package bmhq_pkg;

  localparam int DEPTH    = 256;
  localparam int KEY_BITS = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

>>> hw/rtl/bmhq_ifs.sv
// Valid/ready channel interfaces for the command and result beats.
// Depends on bmhq_pkg.
interface bmhq_cmd_if;
  import bmhq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [KEY_BITS-1:0] key_in;
  modport source (output valid, output cmd, output key_in, input ready);
  modport sink (input valid, input cmd, input key_in, output ready);
endinterface

interface bmhq_res_if;
  import bmhq_pkg::*;
  logic                valid;
  logic                ready;
  logic [31:0]         key_out;
  logic [1:0]          result_status;
  logic [CNT_W-1:0]    entry_count;
  modport source (output valid, output key_out, output result_status,
                  output entry_count, input ready);
  modport sink (input valid, input key_out, input result_status,
                input entry_count, output ready);
endinterface

>>> hw/rtl/bmhq_cell.sv
// One cell of the sorted chain: holds a single key and moves it towards
// or away from the head as its neighbours dictate. Depends on bmhq_pkg.
module bmhq_cell (
  input  logic                          clk,
  input  bmhq_pkg::cell_ctl_t           ctl,
  input  logic [bmhq_pkg::KEY_BITS-1:0] key,
  input  logic                          valid,
  input  logic                          left_keep,
  input  logic [bmhq_pkg::KEY_BITS-1:0] left_value,
  input  logic [bmhq_pkg::KEY_BITS-1:0] right_value,
  output logic                          keep,
  output logic [bmhq_pkg::KEY_BITS-1:0] value
);
  import bmhq_pkg::*;

  logic [KEY_BITS-1:0] value_next;

  assign keep = valid && (value >= key);

  always_comb begin
    value_next = value;
    if (ctl.ins) begin
      if (!keep) begin
        value_next = left_keep ? key : left_value;
      end
    end else if (ctl.pop) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hw/rtl/binary_max_heap_queue.sv
// Max-priority queue built as a chain of key cells kept in descending order.
// Each command beat, once taken, has its result beat in the output
// register on the next cycle; one beat per cycle is sustained while
// the result side takes beats. Reset empties the queue and sets capacity to
// 256; the cell contents are not cleared, as only cells below the count are
// ever used.
module binary_max_heap_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [8:0]                 cfg_wdata,
  bmhq_cmd_if.sink                   cmd_ch,
  bmhq_res_if.source                 res_ch
);
  import bmhq_pkg::*;

  logic [8:0]          capacity;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    limit;
  logic                acc;
  logic                full;
  logic                empty;
  cell_ctl_t           ctl;
  logic [1:0]          status_next;
  logic [31:0]         key_out_next;
  logic [KEY_BITS-1:0] cell_val [DEPTH];
  logic                cell_keep [DEPTH];
  logic                res_valid;
  logic [31:0]         res_key;
  logic [1:0]          res_status;
  logic [CNT_W-1:0]    res_count;

  assign limit  = (CNT_W'(capacity) < CNT_W'(DEPTH)) ? CNT_W'(capacity) : CNT_W'(DEPTH);
  assign full   = count >= limit;
  assign empty  = count == '0;
  assign cmd_ch.ready = !res_valid || res_ch.ready;
  assign acc    = cmd_ch.valid && cmd_ch.ready;

  always_comb begin
    ctl          = '0;
    status_next  = ST_OK;
    key_out_next = '0;
    count_next   = count;
    case (cmd_ch.cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = acc;
          count_next = count + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.pop      = acc;
          key_out_next = 32'(cell_val[0]);
          count_next   = count - 1'b1;
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          key_out_next = 32'(cell_val[0]);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                cl_keep;
    logic [KEY_BITS-1:0] cl_left;
    logic [KEY_BITS-1:0] cr_right;
    if (g == 0) begin : g_head
      assign cl_keep = 1'b1;
      assign cl_left = cmd_ch.key_in;
    end else begin : g_body
      assign cl_keep = cell_keep[g-1];
      assign cl_left = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign cr_right = cell_val[g];
    end else begin : g_mid
      assign cr_right = cell_val[g+1];
    end
    bmhq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (cmd_ch.key_in),
      .valid       (CNT_W'(g) < count),
      .left_keep   (cl_keep),
      .left_value  (cl_left),
      .right_value (cr_right),
      .keep        (cell_keep[g]),
      .value       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= 9'd256;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (acc) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_key    <= key_out_next;
      res_status <= status_next;
      res_count  <= count_next;
    end
  end

  assign res_ch.valid         = res_valid;
  assign res_ch.key_out       = res_key;
  assign res_ch.result_status = res_status;
  assign res_ch.entry_count   = res_count;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (acc && cmd_ch.cmd == CMD_INSERT && !full) |=> count == $past(count) + 1'b1)
    else $error("insert did not add an entry");

  a_head_order : assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> cell_val[0] >= cell_val[1])
    else $error("head cell is not the maximum");

  a_result_count : assert property (@(posedge clk) disable iff (rst)
    acc |=> res_count == count)
    else $error("result count differs from stored count");

endmodule
